[design/co2_link_pkg.sv]
// ----------------------------------------------------------------------------
// co2_link_pkg
// shared types, codes and constants of the co2 sensor link controller
// ----------------------------------------------------------------------------
package co2_link_pkg;

	localparam int VALUE_SLOTS_DEF = 3;
	localparam int QUEUE_DEPTH = 2;

	// request types
	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// parser phases
	localparam logic [3:0] PH_READY = 4'd0;
	localparam logic [3:0] PH_D0    = 4'd1;
	localparam logic [3:0] PH_D4    = 4'd5;
	localparam logic [3:0] PH_D5    = 4'd6;
	localparam logic [3:0] PH_D9    = 4'd10;
	localparam logic [3:0] PH_DONE  = 4'd11;

	// link states
	localparam logic [3:0] LS_INIT  = 4'd0;
	localparam logic [3:0] LS_SETUP = 4'd1;
	localparam logic [3:0] LS_MODE  = 4'd2;
	localparam logic [3:0] LS_CALH  = 4'd3;
	localparam logic [3:0] LS_CALL  = 4'd4;
	localparam logic [3:0] LS_CAL   = 4'd5;
	localparam logic [3:0] LS_IDLE  = 4'd6;
	localparam logic [3:0] LS_OPER  = 4'd7;
	localparam logic [3:0] LS_DONE  = 4'd8;
	localparam logic [3:0] LS_ERROR = 4'd9;

	// command codes
	localparam logic [2:0] CMD_POLL  = 3'd0;
	localparam logic [2:0] CMD_CALH  = 3'd2;
	localparam logic [2:0] CMD_CALL  = 3'd3;
	localparam logic [2:0] CMD_CAL   = 3'd4;
	localparam logic [2:0] CMD_DATA  = 3'd5;
	localparam logic [2:0] CMD_SCALE = 3'd6;

	// reported value kinds
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_CO2    = 3'd1;
	localparam logic [2:0] KIND_SIGNAL = 3'd2;
	localparam logic [2:0] KIND_LED    = 3'd3;
	localparam logic [2:0] KIND_SCALE  = 3'd4;

	// reply characters
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [16:0] VAL_MAX = 17'd99999;
	localparam logic [16:0] CAL_H_A = 17'd10;
	localparam logic [16:0] CAL_H_B = 17'd1;
	localparam logic [16:0] CAL_L_A = 17'd11;
	localparam logic [16:0] CAL_L_B = 17'd144;
	localparam logic [16:0] MODE_K  = 17'd2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LETTER,
		OP_QMARK,
		OP_DIGIT,
		OP_SEP,
		OP_OTHER,
		OP_TICK,
		OP_WRITE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic        cmd_valid;
		logic [2:0]  cmd_code;
		logic [3:0]  link_state;
		logic        connected;
		logic [2:0]  value_kind;
		logic [16:0] value;
	} res_t;

endpackage

[design/co2_link_ifs.sv]
// ----------------------------------------------------------------------------
// co2_link_ifs
// request and result channels of the co2 sensor link controller
// ----------------------------------------------------------------------------
interface co2_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	logic [3:0] new_link_state;

	modport source (output valid, req_type, rx_byte, new_link_state, input ready);
	modport sink (input valid, req_type, rx_byte, new_link_state, output ready);
endinterface

interface co2_res_if;
	logic        valid;
	logic        ready;
	logic        cmd_valid;
	logic [2:0]  cmd_code;
	logic [3:0]  link_state;
	logic        connected;
	logic [2:0]  value_kind;
	logic [16:0] value;

	modport source (output valid, cmd_valid, cmd_code, link_state, connected, value_kind,
		value, input ready);
	modport sink (input valid, cmd_valid, cmd_code, link_state, connected, value_kind,
		value, output ready);
endinterface

[design/co2_link_front.sv]
// ----------------------------------------------------------------------------
// co2_link_front
// accepts request items and classifies them into operations for the back end
// ----------------------------------------------------------------------------
module co2_link_front (
	co2_req_if.sink               req,
	input  logic                  q_ready,
	output logic                  push,
	output co2_link_pkg::q_entry_t push_entry
);
	import co2_link_pkg::*;

	logic [7:0] b;

	assign b = req.rx_byte;
	assign req.ready = q_ready;
	assign push = req.valid & q_ready;

	always_comb begin
		push_entry.op = OP_NOP;
		push_entry.data = b;
		case (req.req_type)
			REQ_BYTE: begin
				if (b == CH_P || b == CH_G || b == CH_K || b == CH_L || b == CH_D ||
						b == CH_Z || b == CH_DOT) begin
					push_entry.op = OP_LETTER;
				end else if (b == CH_QMARK) begin
					push_entry.op = OP_QMARK;
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					push_entry.op = OP_DIGIT;
					push_entry.data = b - CH_ZERO;
				end else if (b == CH_SPACE || b == CH_LF) begin
					push_entry.op = OP_SEP;
				end else begin
					push_entry.op = OP_OTHER;
				end
			end
			REQ_TICK: begin
				push_entry.op = OP_TICK;
			end
			REQ_WRITE: begin
				// out-of-range states are dropped
				if (req.new_link_state <= LS_ERROR) begin
					push_entry.op = OP_WRITE;
				end
				push_entry.data = {4'd0, req.new_link_state};
			end
			default: begin
				push_entry.op = OP_NOP;
			end
		endcase
	end

endmodule

[design/co2_link_queue.sv]
// ----------------------------------------------------------------------------
// co2_link_queue
// short fifo of classified operations between front and back end
// ----------------------------------------------------------------------------
module co2_link_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  co2_link_pkg::q_entry_t push_entry,
	output logic                   q_ready,
	output logic                   q_valid,
	input  logic                   pop,
	output co2_link_pkg::q_entry_t head
);
	import co2_link_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	q_entry_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign q_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[design/co2_link_back.sv]
// ----------------------------------------------------------------------------
// co2_link_back
// reply parser, link state machine and result register
// ----------------------------------------------------------------------------
module co2_link_back #(
	parameter int VALUE_SLOTS = co2_link_pkg::VALUE_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   q_valid,
	input  co2_link_pkg::q_entry_t head,
	output logic                   pop,
	co2_res_if.source              res
);
	import co2_link_pkg::*;

	localparam int SW = $clog2(VALUE_SLOTS);
	localparam logic [SW-1:0] SLOT_LAST = SW'(VALUE_SLOTS - 1);

	logic          sentinel_q;
	logic [3:0]    rx_phase_q, rx_phase_d;
	logic [7:0]    reply_letter_q, reply_letter_d;
	logic [16:0]   field_acc_q [VALUE_SLOTS];
	logic [16:0]   field_acc_d [VALUE_SLOTS];
	logic [SW-1:0] field_slot_q, field_slot_d;
	logic [3:0]    link_now_q, link_now_d;
	logic [3:0]    link_prev_q, link_prev_d;
	logic [16:0]   scale_value_q, scale_value_d;
	logic          link_up_q, link_up_d;
	logic [2:0]    last_cmd_q, last_cmd_d;
	logic          resend_pending_q, resend_pending_d;
	res_t          out_q, res_d;
	logic          out_valid_q;

	logic [16:0]   acc_cur;
	logic [19:0]   acc_mul;
	logic [16:0]   acc_sat;
	logic          is_p;
	logic [SW-1:0] slot_nxt;
	logic [3:0]    s;
	logic          snd;

	assign pop = q_valid & (~out_valid_q | res.ready);

	assign acc_cur = field_acc_q[field_slot_q];
	assign acc_mul = {acc_cur, 3'b000} + {2'b00, acc_cur, 1'b0} + {16'd0, head.data[3:0]};
	assign acc_sat = (acc_mul > {3'd0, VAL_MAX}) ? VAL_MAX : acc_mul[16:0];
	assign is_p = (reply_letter_q == CH_P);
	assign slot_nxt = (field_slot_q < SLOT_LAST) ? field_slot_q + 1'b1 : field_slot_q;

	always_comb begin
		rx_phase_d = rx_phase_q;
		reply_letter_d = reply_letter_q;
		field_acc_d = field_acc_q;
		field_slot_d = field_slot_q;
		link_now_d = link_now_q;
		link_prev_d = link_prev_q;
		scale_value_d = scale_value_q;
		link_up_d = link_up_q;
		last_cmd_d = last_cmd_q;
		resend_pending_d = resend_pending_q;
		res_d = '0;
		snd = 1'b1;
		s = (link_now_q == LS_ERROR) ? link_prev_q : link_now_q;

		case (head.op)
			OP_LETTER, OP_QMARK, OP_DIGIT, OP_SEP, OP_OTHER: begin
				if (rx_phase_q == PH_READY) begin
					if (head.op == OP_LETTER) begin
						reply_letter_d = head.data;
						rx_phase_d = PH_D0;
						field_acc_d[0] = '0;
						field_slot_d = '0;
					end else if (head.op == OP_QMARK) begin
						link_now_d = LS_ERROR;
					end
				end else if (head.op == OP_DIGIT) begin
					if (rx_phase_q >= PH_D0 && rx_phase_q <= PH_D9) begin
						field_acc_d[field_slot_q] = acc_sat;
						if ((is_p && rx_phase_q == PH_D9) || (!is_p && rx_phase_q == PH_D4)) begin
							rx_phase_d = PH_DONE;
						end else begin
							rx_phase_d = rx_phase_q + 1'b1;
						end
					end else if (rx_phase_q != PH_DONE) begin
						rx_phase_d = PH_READY;
					end
				end else if (head.op == OP_SEP) begin
					if (rx_phase_q == PH_DONE) begin
						// reply complete
						link_up_d = 1'b1;
						case (link_now_q)
							LS_SETUP: begin
								if (reply_letter_q == CH_DOT) link_now_d = LS_MODE;
							end
							LS_MODE: begin
								if (reply_letter_q == CH_K && acc_cur == MODE_K) link_now_d = LS_IDLE;
							end
							LS_CALH: begin
								link_now_d = (is_p && field_acc_q[0] == CAL_H_A &&
									field_acc_q[1] == CAL_H_B) ? LS_CALL : LS_IDLE;
							end
							LS_CALL: begin
								link_now_d = (is_p && field_acc_q[0] == CAL_L_A &&
									field_acc_q[1] == CAL_L_B) ? LS_CAL : LS_IDLE;
							end
							default: begin
								link_now_d = LS_IDLE;
							end
						endcase
						if (reply_letter_q == CH_D) begin
							res_d.value_kind = KIND_SIGNAL;
							res_d.value = acc_cur;
						end else if (reply_letter_q == CH_L) begin
							res_d.value_kind = KIND_LED;
							res_d.value = acc_cur;
						end else if (reply_letter_q == CH_Z) begin
							res_d.value_kind = KIND_CO2;
							res_d.value = acc_cur;
							if (sentinel_q) link_now_d = LS_DONE;
						end else if (reply_letter_q == CH_DOT) begin
							res_d.value_kind = KIND_SCALE;
							res_d.value = acc_cur;
							scale_value_d = acc_cur;
						end
					end else if (rx_phase_q == PH_D5 && is_p) begin
						field_slot_d = slot_nxt;
						field_acc_d[slot_nxt] = '0;
					end
					if (rx_phase_q != PH_D0 && rx_phase_q != PH_D5) rx_phase_d = PH_READY;
				end else if (rx_phase_q >= PH_D0 && rx_phase_q <= PH_D4) begin
					rx_phase_d = PH_READY;
				end
			end
			OP_TICK: begin
				case (s)
					LS_INIT: begin
						link_up_d = 1'b0;
						scale_value_d = '0;
						s = LS_SETUP;
						res_d.cmd_code = CMD_SCALE;
					end
					LS_SETUP: begin
						if (scale_value_q == '0) begin
							res_d.cmd_code = CMD_SCALE;
						end else begin
							res_d.cmd_code = CMD_POLL;
							s = LS_MODE;
						end
					end
					LS_MODE: res_d.cmd_code = CMD_POLL;
					LS_CALH: res_d.cmd_code = CMD_CALH;
					LS_CALL: res_d.cmd_code = CMD_CALL;
					LS_CAL: begin
						res_d.cmd_code = CMD_CAL;
						s = LS_IDLE;
					end
					LS_IDLE: begin
						if (scale_value_q == '0) begin
							res_d.cmd_code = CMD_SCALE;
							s = LS_SETUP;
						end else begin
							res_d.cmd_code = CMD_DATA;
							s = LS_OPER;
						end
					end
					default: begin
						// resend last command once
						snd = 1'b0;
						if (resend_pending_q) begin
							res_d.cmd_valid = 1'b1;
							res_d.cmd_code = last_cmd_q;
							resend_pending_d = 1'b0;
						end else begin
							res_d.cmd_code = CMD_POLL;
						end
					end
				endcase
				if (snd) begin
					res_d.cmd_valid = 1'b1;
					last_cmd_d = res_d.cmd_code;
					resend_pending_d = 1'b1;
				end
				link_prev_d = s;
				link_now_d = s;
			end
			OP_WRITE: begin
				link_now_d = head.data[3:0];
			end
			default: begin
			end
		endcase
		res_d.link_state = link_now_d;
		res_d.connected = link_up_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_q <= 1'b0;
			rx_phase_q <= PH_READY;
			reply_letter_q <= '0;
			for (int i = 0; i < VALUE_SLOTS; i++) field_acc_q[i] <= '0;
			field_slot_q <= '0;
			link_now_q <= LS_INIT;
			link_prev_q <= LS_INIT;
			scale_value_q <= '0;
			link_up_q <= 1'b0;
			last_cmd_q <= CMD_POLL;
			resend_pending_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) sentinel_q <= cfg_wdata;
			if (pop) begin
				rx_phase_q <= rx_phase_d;
				reply_letter_q <= reply_letter_d;
				field_acc_q <= field_acc_d;
				field_slot_q <= field_slot_d;
				link_now_q <= link_now_d;
				link_prev_q <= link_prev_d;
				scale_value_q <= scale_value_d;
				link_up_q <= link_up_d;
				last_cmd_q <= last_cmd_d;
				resend_pending_q <= resend_pending_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_q <= res_d;
	end

	assign res.valid = out_valid_q;
	assign res.cmd_valid = out_q.cmd_valid;
	assign res.cmd_code = out_q.cmd_code;
	assign res.link_state = out_q.link_state;
	assign res.connected = out_q.connected;
	assign res.value_kind = out_q.value_kind;
	assign res.value = out_q.value;

endmodule

[design/co2_sensor_uart_link_unit.sv]
// ----------------------------------------------------------------------------
// co2_sensor_uart_link_unit
// Link controller for a UART CO2 sensor. Every request item (received byte,
// control tick or link state write) yields exactly one result item carrying
// the command to send, the link state, the connected flag and any reported
// value. The block takes one item per clock cycle while the output is not
// stalled: a classifier accepts items into a two-entry queue, and the back
// end pops each item into the parser, link state and result register, so
// an item passes the queue register and then the result register. The
// sentinel mode register (sentinel_q) is written through cfg_we and cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module co2_sensor_uart_link_unit #(
	parameter int VALUE_SLOTS = co2_link_pkg::VALUE_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	co2_req_if.sink   req,
	co2_res_if.source res
);
	import co2_link_pkg::*;

	logic     q_ready;
	logic     q_valid;
	logic     push;
	logic     pop;
	q_entry_t push_entry;
	q_entry_t head;

	co2_link_front u_front (
		.req        (req),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	co2_link_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.q_valid    (q_valid),
		.pop        (pop),
		.head       (head)
	);

	co2_link_back #(
		.VALUE_SLOTS (VALUE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.res       (res)
	);

endmodule
